FILE: sv/i2cwrs_pkg.sv
// Shared types and codes for the I2C write/read sequencer.
// Holds the request/response item layouts, bus status codes, commands and outcomes.
// No dependencies.
package i2cwrs_pkg;

   // request kinds
   localparam logic [1:0] ACT_LOAD   = 2'd0;
   localparam logic [1:0] ACT_BEGIN  = 2'd1;
   localparam logic [1:0] ACT_STATUS = 2'd2;

   // bus status codes, prescaler bits cleared
   localparam logic [7:0] STATUS_MASK       = 8'hF8;
   localparam logic [7:0] BUS_START         = 8'h08;
   localparam logic [7:0] BUS_REP_START     = 8'h10;
   localparam logic [7:0] BUS_MT_ADDR_ACK   = 8'h18;
   localparam logic [7:0] BUS_MT_ADDR_NACK  = 8'h20;
   localparam logic [7:0] BUS_MT_DATA_ACK   = 8'h28;
   localparam logic [7:0] BUS_MR_ADDR_ACK   = 8'h40;
   localparam logic [7:0] BUS_MR_ADDR_NACK  = 8'h48;
   localparam logic [7:0] BUS_MR_DATA_ACK   = 8'h50;
   localparam logic [7:0] BUS_MR_DATA_NACK  = 8'h58;
   localparam logic [7:0] BUS_NO_INFO       = 8'hF8;

   // bus commands
   localparam logic [2:0] CMD_NONE  = 3'd0;
   localparam logic [2:0] CMD_START = 3'd1;
   localparam logic [2:0] CMD_SEND  = 3'd2;
   localparam logic [2:0] CMD_RDACK = 3'd3;
   localparam logic [2:0] CMD_RDNAK = 3'd4;
   localparam logic [2:0] CMD_STOP  = 3'd5;

   // outcomes
   localparam logic [2:0] OC_BUSY       = 3'd0;
   localparam logic [2:0] OC_WRITE_DONE = 3'd1;
   localparam logic [2:0] OC_READ_DONE  = 3'd2;
   localparam logic [2:0] OC_UNEXPECTED = 3'd3;
   localparam logic [2:0] OC_REJECTED   = 3'd4;

   // width that holds any byte count up to the largest buffer
   localparam int CNT_W = 9;

   typedef struct packed {
      logic [1:0] action;
      logic [5:0] load_index;
      logic [7:0] load_byte;
      logic [6:0] device_address;
      logic [6:0] write_count;
      logic [6:0] read_count;
      logic [7:0] bus_status;
      logic [7:0] bus_rx_byte;
   } req_type;

   typedef struct packed {
      logic [2:0] bus_command;
      logic [7:0] tx_byte;
      logic       rx_valid;
      logic [5:0] rx_index;
      logic [7:0] rx_data;
      logic [2:0] outcome;
      logic [7:0] final_status;
   } rsp_type;

   typedef struct packed {
      logic [6:0] writes_left;
      logic [6:0] reads_left;
      logic [6:0] target_address;
      logic       transaction_active;
   } ctx_type;

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } state_type;

endpackage

FILE: sv/i2cwrs_buffer.sv
// Byte buffer of the I2C write/read sequencer: one write port, one read port
// with registered read data. No package dependencies.
module i2cwrs_buffer #(
   parameter int BUFFER_DEPTH = 64
) (
   input  logic                            clock,
   input  logic                            wr_en,
   input  logic [$clog2(BUFFER_DEPTH)-1:0] wr_addr,
   input  logic [7:0]                      wr_data,
   input  logic                            rd_en,
   input  logic [$clog2(BUFFER_DEPTH)-1:0] rd_addr,
   output logic [7:0]                      rd_data
);

   logic [7:0] mem [BUFFER_DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // hold read data until the next read so a stalled step still sees it
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/i2cwrs_decode.sv
// Step logic of the I2C write/read sequencer: from one request, the
// transaction context and the buffer byte at the pointer, forms the result,
// the next context and the buffer write. Depends on i2cwrs_pkg.
module i2cwrs_decode import i2cwrs_pkg::*; #(
   parameter int BUFFER_DEPTH = 64
) (
   input  req_type                                 item,
   input  ctx_type                                 ctx,
   input  logic [$clog2(BUFFER_DEPTH+1)-1:0]       ptr,
   input  logic [7:0]                              rd_data,
   output rsp_type                                 result,
   output ctx_type                                 ctx_next,
   output logic [$clog2(BUFFER_DEPTH+1)-1:0]       ptr_next,
   output logic                                    wr_en,
   output logic [$clog2(BUFFER_DEPTH)-1:0]         wr_addr,
   output logic [7:0]                              wr_data
);

   localparam int ADDR_W = $clog2(BUFFER_DEPTH);
   localparam int PTR_W  = $clog2(BUFFER_DEPTH + 1);

   logic [7:0]       status;
   logic [CNT_W-1:0] total;
   logic             ptr_in_range;
   logic [6:0]       reads_dec;

   always_comb begin
      status       = item.bus_status & STATUS_MASK;
      total        = CNT_W'(item.write_count) + CNT_W'(item.read_count);
      ptr_in_range = CNT_W'(ptr) < CNT_W'(BUFFER_DEPTH);
      reads_dec    = (ctx.reads_left != 7'd0) ? ctx.reads_left - 7'd1 : 7'd0;

      result   = '0;
      ctx_next = ctx;
      ptr_next = ptr;
      wr_en    = 1'b0;
      wr_addr  = ADDR_W'(ptr);
      wr_data  = item.bus_rx_byte;

      unique case (item.action)
         ACT_LOAD: begin
            if (CNT_W'(item.load_index) < CNT_W'(BUFFER_DEPTH)) begin
               wr_en   = 1'b1;
               wr_addr = ADDR_W'(item.load_index);
               wr_data = item.load_byte;
            end
         end
         ACT_BEGIN: begin
            if (total > CNT_W'(BUFFER_DEPTH)) begin
               result.outcome = OC_REJECTED;
            end else begin
               ctx_next.target_address     = item.device_address;
               ctx_next.writes_left        = item.write_count;
               ctx_next.reads_left         = item.read_count;
               ctx_next.transaction_active = 1'b1;
               ptr_next                    = '0;
               result.bus_command          = CMD_START;
            end
         end
         ACT_STATUS: begin
            if (ctx.transaction_active) begin
               unique case (status)
                  BUS_NO_INFO, BUS_MT_ADDR_NACK, BUS_MR_ADDR_NACK: begin
                     result.bus_command = CMD_START;
                  end
                  BUS_START, BUS_REP_START: begin
                     result.bus_command = CMD_SEND;
                     result.tx_byte     = {ctx.target_address, ctx.writes_left == 7'd0};
                  end
                  BUS_MT_ADDR_ACK, BUS_MT_DATA_ACK: begin
                     if (ctx.writes_left != 7'd0) begin
                        ctx_next.writes_left = ctx.writes_left - 7'd1;
                        result.bus_command   = CMD_SEND;
                        if (ptr_in_range) begin
                           result.tx_byte = rd_data;
                           ptr_next       = PTR_W'(ptr + 1'b1);
                        end
                     end else if (ctx.reads_left == 7'd0) begin
                        result.bus_command          = CMD_STOP;
                        result.outcome              = OC_WRITE_DONE;
                        result.final_status         = status;
                        ctx_next.transaction_active = 1'b0;
                     end else begin
                        // writes done, reads pending: repeated start
                        result.bus_command = CMD_START;
                     end
                  end
                  BUS_MR_DATA_NACK: begin
                     if (ptr_in_range) begin
                        wr_en           = 1'b1;
                        result.rx_valid = 1'b1;
                        result.rx_index = 6'(ptr);
                        result.rx_data  = item.bus_rx_byte;
                        ptr_next        = PTR_W'(ptr + 1'b1);
                     end
                     result.bus_command          = CMD_STOP;
                     result.outcome              = OC_READ_DONE;
                     result.final_status         = status;
                     ctx_next.transaction_active = 1'b0;
                  end
                  BUS_MR_DATA_ACK: begin
                     if (ptr_in_range) begin
                        wr_en           = 1'b1;
                        result.rx_valid = 1'b1;
                        result.rx_index = 6'(ptr);
                        result.rx_data  = item.bus_rx_byte;
                        ptr_next        = PTR_W'(ptr + 1'b1);
                     end
                     ctx_next.reads_left = reads_dec;
                     result.bus_command  = (reads_dec != 7'd0) ? CMD_RDACK : CMD_RDNAK;
                  end
                  BUS_MR_ADDR_ACK: begin
                     ctx_next.reads_left = reads_dec;
                     result.bus_command  = (reads_dec != 7'd0) ? CMD_RDACK : CMD_RDNAK;
                  end
                  default: begin
                     result.bus_command          = CMD_STOP;
                     result.outcome              = OC_UNEXPECTED;
                     result.final_status         = status;
                     ctx_next.transaction_active = 1'b0;
                  end
               endcase
            end
         end
         default: begin
            // unused request kind: no effect
         end
      endcase
   end

endmodule

FILE: sv/i2c_write_read_sequencer_top.sv
// Top level of the I2C write/read sequencer: request/response streams,
// step sequencing, context registers and output register.
// Depends on i2cwrs_pkg, i2cwrs_buffer and i2cwrs_decode.
//
// Channel   Direction  Transfer condition          Contents
// req_*     in         req_tvalid && req_tready    load byte, begin, bus status event
// rsp_*     out        rsp_tvalid && rsp_tready    one result per request
//
// Each request takes two steps: a read of the byte buffer at the current
// pointer (synchronous memory, registered read data), then decode and
// write back of context and buffer. A request is accepted while the previous
// result still waits in the output register; the decode step holds while that
// register is full and not taken. Reset is synchronous and clears the context;
// the buffer is not cleared and reads of unwritten entries are undefined.
module i2c_write_read_sequencer_top import i2cwrs_pkg::*; #(
   parameter int BUFFER_DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [5:0] load_index, [13:6] load_byte, [20:14] device_address,
   // [27:21] write_count, [34:28] read_count, [42:35] bus_status,
   // [50:43] bus_rx_byte, [55:51] zero
   input  logic [55:0] req_tdata,
   // [1:0] action
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] tx_byte, [13:8] rx_index, [21:14] rx_data, [24:22] outcome,
   // [32:25] final_status, [39:33] zero
   output logic [39:0] rsp_tdata,
   // [2:0] bus_command, [3] rx_valid
   output logic [3:0]  rsp_tuser
);

   localparam int ADDR_W = $clog2(BUFFER_DEPTH);
   localparam int PTR_W  = $clog2(BUFFER_DEPTH + 1);

   state_type          state_ff, state_in;
   req_type            item_ff, item_in;
   ctx_type            ctx_ff, ctx_in;
   logic [PTR_W-1:0]   ptr_ff, ptr_in;
   rsp_type            rsp_ff;
   logic               rsp_valid_ff;

   logic               accept;
   logic               commit;
   logic               rd_en;
   logic [7:0]         rd_data;
   rsp_type            result;
   logic               dec_wr_en;
   logic [ADDR_W-1:0]  dec_wr_addr;
   logic [7:0]         dec_wr_data;

   assign item_in.action         = req_tuser;
   assign item_in.load_index     = req_tdata[5:0];
   assign item_in.load_byte      = req_tdata[13:6];
   assign item_in.device_address = req_tdata[20:14];
   assign item_in.write_count    = req_tdata[27:21];
   assign item_in.read_count     = req_tdata[34:28];
   assign item_in.bus_status     = req_tdata[42:35];
   assign item_in.bus_rx_byte    = req_tdata[50:43];

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rd_en      = accept && (CNT_W'(ptr_ff) < CNT_W'(BUFFER_DEPTH));

   i2cwrs_buffer #(
      .BUFFER_DEPTH (BUFFER_DEPTH)
   ) u_buffer (
      .clock   (clock),
      .wr_en   (dec_wr_en && commit),
      .wr_addr (dec_wr_addr),
      .wr_data (dec_wr_data),
      .rd_en   (rd_en),
      .rd_addr (ADDR_W'(ptr_ff)),
      .rd_data (rd_data)
   );

   i2cwrs_decode #(
      .BUFFER_DEPTH (BUFFER_DEPTH)
   ) u_decode (
      .item     (item_ff),
      .ctx      (ctx_ff),
      .ptr      (ptr_ff),
      .rd_data  (rd_data),
      .result   (result),
      .ctx_next (ctx_in),
      .ptr_next (ptr_in),
      .wr_en    (dec_wr_en),
      .wr_addr  (dec_wr_addr),
      .wr_data  (dec_wr_data)
   );

   always_comb begin
      state_in = state_ff;
      commit   = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            // hold the step until the output register can take its result
            if (!rsp_valid_ff || rsp_tready) begin
               commit   = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctx_ff       <= '0;
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (commit) begin
            ctx_ff       <= ctx_in;
            ptr_ff       <= ptr_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
      if (commit) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_ff.final_status, rsp_ff.outcome, rsp_ff.rx_data,
                        rsp_ff.rx_index, rsp_ff.tx_byte};
   assign rsp_tuser  = {rsp_ff.rx_valid, rsp_ff.bus_command};

`ifndef ASSERT_OFF
   // a stored received byte only comes with a read or the closing stop
   a_rx_with_read: assert property (@(posedge clock) disable iff (reset)
      commit && result.rx_valid |->
         result.bus_command == CMD_RDACK || result.bus_command == CMD_RDNAK ||
         result.bus_command == CMD_STOP)
      else $error("received byte stored without a read command");

   // a rejected begin issues no bus command and leaves the context alone
   a_reject_quiet: assert property (@(posedge clock) disable iff (reset)
      commit && result.outcome == OC_REJECTED |=>
         rsp_ff.bus_command == CMD_NONE && $stable(ctx_ff) && $stable(ptr_ff))
      else $error("rejected begin changed state or issued a command");

   // every ending outcome closes the transaction
   a_end_closes: assert property (@(posedge clock) disable iff (reset)
      commit && (result.outcome == OC_WRITE_DONE || result.outcome == OC_READ_DONE ||
                 result.outcome == OC_UNEXPECTED) |=> !ctx_ff.transaction_active)
      else $error("transaction still active after its end");

   // the buffer pointer saturates at the buffer depth
   a_ptr_bound: assert property (@(posedge clock) disable iff (reset)
      CNT_W'(ptr_ff) <= CNT_W'(BUFFER_DEPTH))
      else $error("buffer pointer beyond buffer depth");
`endif

endmodule

FILE: test/i2c_write_read_sequencer_top_test.sv
`timescale 1ns / 1ps
// Stream-level test of the I2C write/read sequencer: directed and random bus transactions.
// Predicts each result from its own copy of buffer and transfer state; uses i2cwrs_pkg.
module i2c_write_read_sequencer_top_test;
   import i2cwrs_pkg::*;

   localparam int DEPTH = 64;
   localparam logic [1:0] ACT_UNUSED = 2'd3;
   localparam logic [7:0] KNOWN_STATUS [10] = '{BUS_START, BUS_REP_START, BUS_MT_ADDR_ACK,
      BUS_MT_ADDR_NACK, BUS_MT_DATA_ACK, BUS_MR_ADDR_ACK, BUS_MR_ADDR_NACK, BUS_MR_DATA_ACK,
      BUS_MR_DATA_NACK, BUS_NO_INFO};

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [55:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;
   logic [3:0]  rsp_tuser;

   // predicted block state
   logic [7:0] buf_mem [DEPTH];
   bit         buf_written [DEPTH];
   logic [6:0] xfer_ptr;
   logic [6:0] writes_due;
   logic [6:0] reads_due;
   logic [6:0] target_addr;
   bit         xfer_active;

   rsp_type bus_steps_due [$];
   rsp_type got_step;
   rsp_type want_step;
   int errors;
   int checked;
   int steps_done;
   int ends_by_outcome [8];
   int burst_left;
   bit sender_gaps_on;
   bit receiver_stalls_on;
   logic [31:0] stall_pattern;
   int stall_phase;

   i2c_write_read_sequencer_top #(.BUFFER_DEPTH(DEPTH)) DUT (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("tb: failure");
      $finish;
   end

   // next bus command and outcome for one request; advances the predicted state
   function automatic rsp_type next_bus_step(input req_type r);
      rsp_type o;
      logic [7:0] st;
      logic [2:0] done;
      bit take_rx;
      bit read_next;
      o = '0;
      st = r.bus_status & STATUS_MASK;
      done = OC_BUSY;
      take_rx = 1'b0;
      read_next = 1'b0;
      if (r.action == ACT_LOAD) begin
         buf_mem[r.load_index] = r.load_byte;
         buf_written[r.load_index] = 1'b1;
      end else if (r.action == ACT_BEGIN) begin
         if ({1'b0, r.write_count} + {1'b0, r.read_count} > 8'(DEPTH)) begin
            o.outcome = OC_REJECTED;
         end else begin
            target_addr = r.device_address;
            writes_due = r.write_count;
            reads_due = r.read_count;
            xfer_ptr = '0;
            xfer_active = 1'b1;
            o.bus_command = CMD_START;
         end
      end else if (r.action == ACT_STATUS && xfer_active) begin
         case (st)
            BUS_NO_INFO, BUS_MT_ADDR_NACK, BUS_MR_ADDR_NACK: o.bus_command = CMD_START;
            BUS_START, BUS_REP_START: begin
               o.bus_command = CMD_SEND;
               o.tx_byte = {target_addr, writes_due == 7'd0};
            end
            BUS_MT_ADDR_ACK, BUS_MT_DATA_ACK: begin
               if (writes_due != 7'd0) begin
                  writes_due = writes_due - 7'd1;
                  o.bus_command = CMD_SEND;
                  if (xfer_ptr < DEPTH) begin
                     o.tx_byte = buf_mem[xfer_ptr[5:0]];
                     xfer_ptr = xfer_ptr + 7'd1;
                  end
               end else if (reads_due == 7'd0) begin
                  done = OC_WRITE_DONE;
               end else begin
                  o.bus_command = CMD_START;
               end
            end
            BUS_MR_DATA_NACK: begin
               take_rx = 1'b1;
               done = OC_READ_DONE;
            end
            BUS_MR_DATA_ACK: begin
               take_rx = 1'b1;
               read_next = 1'b1;
            end
            BUS_MR_ADDR_ACK: read_next = 1'b1;
            default: done = OC_UNEXPECTED;
         endcase
         if (take_rx && xfer_ptr < DEPTH) begin
            buf_mem[xfer_ptr[5:0]] = r.bus_rx_byte;
            buf_written[xfer_ptr[5:0]] = 1'b1;
            o.rx_valid = 1'b1;
            o.rx_index = xfer_ptr[5:0];
            o.rx_data = r.bus_rx_byte;
            xfer_ptr = xfer_ptr + 7'd1;
         end
         if (read_next) begin
            // count stops at zero: the last read is NACKed
            if (reads_due != 7'd0) reads_due = reads_due - 7'd1;
            o.bus_command = (reads_due != 7'd0) ? CMD_RDACK : CMD_RDNAK;
         end
         if (done != OC_BUSY) begin
            o.bus_command = CMD_STOP;
            o.outcome = done;
            o.final_status = st;
            xfer_active = 1'b0;
         end
      end
      return o;
   endfunction

   function automatic req_type random_req(input logic [1:0] act);
      req_type r;
      r.action = act;
      r.load_index = 6'($urandom_range(0, 63));
      r.load_byte = 8'($urandom_range(0, 255));
      r.device_address = 7'($urandom_range(0, 127));
      r.write_count = 7'($urandom_range(0, 127));
      r.read_count = 7'($urandom_range(0, 127));
      r.bus_status = 8'($urandom_range(0, 255));
      r.bus_rx_byte = 8'($urandom_range(0, 255));
      return r;
   endfunction

   function automatic logic [7:0] random_status();
      if ($urandom_range(0, 1) == 0) return KNOWN_STATUS[$urandom_range(0, 9)];
      return 8'($urandom_range(0, 255));
   endfunction

   // one transfer on the request channel; while gaps are on, the sender pauses between bursts
   task automatic drive_item(input req_type r);
      rsp_type o;
      bit ignored;
      if (sender_gaps_on && burst_left == 0) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
         burst_left = $urandom_range(1, 12);
      end
      if (burst_left > 0) burst_left--;
      req_tuser = r.action;
      req_tdata = {5'b0, r.bus_rx_byte, r.bus_status, r.read_count, r.write_count,
                   r.device_address, r.load_byte, r.load_index};
      req_tvalid = 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      ignored = (r.action == ACT_UNUSED) || (r.action == ACT_STATUS && !xfer_active);
      o = next_bus_step(r);
      bus_steps_due.push_back(o);
      if (!ignored) steps_done++;
      ends_by_outcome[o.outcome]++;
      @(negedge clock);
   endtask

   // never let the block send a buffer entry that holds no data: load it first
   task automatic send_item(input req_type r);
      req_type fill;
      logic [7:0] st;
      st = r.bus_status & STATUS_MASK;
      if (r.action == ACT_STATUS && xfer_active
          && (st == BUS_MT_ADDR_ACK || st == BUS_MT_DATA_ACK)
          && writes_due != 7'd0 && xfer_ptr < DEPTH && !buf_written[xfer_ptr[5:0]]) begin
         fill = random_req(ACT_LOAD);
         fill.load_index = xfer_ptr[5:0];
         drive_item(fill);
      end
      drive_item(r);
   endtask

   task automatic load_byte_at(input logic [5:0] idx, input logic [7:0] b);
      req_type r;
      r = random_req(ACT_LOAD);
      r.load_index = idx;
      r.load_byte = b;
      send_item(r);
   endtask

   task automatic begin_xfer(input logic [6:0] addr, input logic [6:0] wc, input logic [6:0] rc);
      req_type r;
      r = random_req(ACT_BEGIN);
      r.device_address = addr;
      r.write_count = wc;
      r.read_count = rc;
      send_item(r);
   endtask

   // status code with random prescaler bits
   task automatic bus_event(input logic [7:0] code);
      req_type r;
      r = random_req(ACT_STATUS);
      r.bus_status = code | 8'($urandom_range(0, 7));
      send_item(r);
   endtask

   // check each result transfer against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_step.bus_command = rsp_tuser[2:0];
         got_step.rx_valid = rsp_tuser[3];
         got_step.tx_byte = rsp_tdata[7:0];
         got_step.rx_index = rsp_tdata[13:8];
         got_step.rx_data = rsp_tdata[21:14];
         got_step.outcome = rsp_tdata[24:22];
         got_step.final_status = rsp_tdata[32:25];
         if (bus_steps_due.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("result with nothing pending: cmd %0d tx %h out %0d", got_step.bus_command,
                        got_step.tx_byte, got_step.outcome);
         end else begin
            want_step = bus_steps_due.pop_front();
            checked++;
            if (got_step.bus_command !== want_step.bus_command
                || got_step.tx_byte !== want_step.tx_byte
                || got_step.rx_valid !== want_step.rx_valid
                || got_step.rx_index !== want_step.rx_index
                || got_step.rx_data !== want_step.rx_data
                || got_step.outcome !== want_step.outcome
                || got_step.final_status !== want_step.final_status) begin
               errors++;
               if (errors <= 10) begin
                  $display("mismatch at result %0d: cmd/tx/rxv/rxi/rxd/out/st", checked);
                  $display("  expected %0d %h %0d %0d %h %0d %h", want_step.bus_command,
                           want_step.tx_byte, want_step.rx_valid, want_step.rx_index,
                           want_step.rx_data, want_step.outcome, want_step.final_status);
                  $display("  actual   %0d %h %0d %0d %h %0d %h", got_step.bus_command,
                           got_step.tx_byte, got_step.rx_valid, got_step.rx_index,
                           got_step.rx_data, got_step.outcome, got_step.final_status);
               end
            end
         end
      end
   end

   // receiver: while stalls are on, ready follows a rotating random pattern, reloaded now and then
   initial begin
      rsp_tready = 1'b0;
      stall_phase = 0;
      forever begin
         @(negedge clock);
         if (stall_phase == 0) begin
            stall_pattern = $urandom | $urandom | 32'h1;
            stall_phase = 96;
         end
         rsp_tready = !receiver_stalls_on || stall_pattern[0];
         stall_pattern = {stall_pattern[0], stall_pattern[31:1]};
         stall_phase--;
      end
   end

   task automatic test_write_transfer();
      load_byte_at(6'd0, 8'hFF);
      load_byte_at(6'd1, 8'h00);
      load_byte_at(6'd63, 8'hA5);
      begin_xfer(7'h7F, 7'd2, 7'd0);
      bus_event(BUS_START);
      bus_event(BUS_MT_ADDR_ACK);
      bus_event(BUS_MT_DATA_ACK);
      bus_event(BUS_MT_DATA_ACK);
   endtask

   task automatic test_write_read_transfer();
      begin_xfer(7'h00, 7'd1, 7'd2);
      bus_event(BUS_START);
      bus_event(BUS_MT_ADDR_NACK);
      bus_event(BUS_START);
      bus_event(BUS_MT_ADDR_ACK);
      bus_event(BUS_MT_DATA_ACK);
      bus_event(BUS_REP_START);
      bus_event(BUS_MR_ADDR_ACK);
      bus_event(BUS_MR_DATA_ACK);
      bus_event(BUS_MR_DATA_NACK);
   endtask

   task automatic test_special_cases();
      begin_xfer(7'h11, 7'd64, 7'd1);
      begin_xfer(7'h22, 7'd127, 7'd127);
      bus_event(BUS_START);
      send_item(random_req(ACT_UNUSED));
      begin_xfer(7'h55, 7'd0, 7'd0);
      bus_event(BUS_START);
      bus_event(BUS_MR_ADDR_ACK);
      bus_event(BUS_MR_ADDR_NACK);
      bus_event(BUS_NO_INFO);
      // replace the running transfer
      begin_xfer(7'h2A, 7'd0, 7'd1);
      bus_event(8'h38);
   endtask

   // fill past the buffer end, then a write send with the pointer already at the end
   task automatic test_pointer_saturation();
      begin_xfer(7'($urandom_range(0, 127)), 7'd0, 7'd64);
      bus_event(BUS_START);
      bus_event(BUS_MR_ADDR_ACK);
      repeat (66) bus_event(BUS_MR_DATA_ACK);
      bus_event(BUS_MR_DATA_NACK);
      begin_xfer(7'($urandom_range(0, 127)), 7'd1, 7'd63);
      repeat (65) bus_event(BUS_MR_DATA_ACK);
      bus_event(BUS_MT_DATA_ACK);
      bus_event(BUS_MT_DATA_ACK);
   endtask

   // a well-formed transaction with random content, now and then a corrupted status; or a begin too large to accept
   task automatic run_transaction();
      int wc;
      int rc;
      logic [6:0] addr;
      addr = 7'($urandom_range(0, 127));
      if ($urandom_range(0, 11) == 0) begin
         wc = $urandom_range(1, 64);
         begin_xfer(addr, 7'(wc), 7'($urandom_range(65 - wc, 64)));
         return;
      end
      wc = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 64) : $urandom_range(0, 6);
      rc = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 64 - wc)
                                       : $urandom_range(0, (64 - wc < 6) ? 64 - wc : 6);
      for (int i = 0; i < wc; i++)
         if (!buf_written[i] || $urandom_range(0, 1) == 1)
            load_byte_at(6'(i), 8'($urandom_range(0, 255)));
      begin_xfer(addr, 7'(wc), 7'(rc));
      if ($urandom_range(0, 5) == 0) begin
         bus_event(BUS_START);
         bus_event(wc != 0 ? BUS_MT_ADDR_NACK : BUS_MR_ADDR_NACK);
      end
      if ($urandom_range(0, 9) == 0) bus_event(BUS_NO_INFO);
      bus_event(BUS_START);
      if (wc != 0) begin
         bus_event(BUS_MT_ADDR_ACK);
         for (int i = 0; i < wc; i++)
            bus_event(($urandom_range(0, 39) == 0) ? random_status() : BUS_MT_DATA_ACK);
         if (rc == 0) return;
         bus_event(BUS_REP_START);
      end
      bus_event(BUS_MR_ADDR_ACK);
      for (int i = 1; i < rc; i++)
         bus_event(($urandom_range(0, 39) == 0) ? random_status() : BUS_MR_DATA_ACK);
      bus_event(BUS_MR_DATA_NACK);
   endtask

   task automatic test_random_traffic(input int budget);
      int base;
      base = steps_done;
      while (steps_done - base < budget) begin
         sender_gaps_on = ($urandom_range(0, 4) != 0);
         receiver_stalls_on = ($urandom_range(0, 4) != 0);
         if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 4)) begin
               if ($urandom_range(0, 1) == 0)
                  send_item(random_req(2'($urandom_range(0, 3))));
               else
                  bus_event(random_status());
            end
         end else begin
            run_transaction();
         end
      end
   endtask

   initial begin
      int base;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = ACT_LOAD;
      errors = 0;
      checked = 0;
      steps_done = 0;
      burst_left = 0;
      sender_gaps_on = 1'b1;
      receiver_stalls_on = 1'b1;
      foreach (ends_by_outcome[i]) ends_by_outcome[i] = 0;
      foreach (buf_written[i]) buf_written[i] = 1'b0;
      foreach (buf_mem[i]) buf_mem[i] = '0;
      xfer_ptr = '0;
      writes_due = '0;
      reads_due = '0;
      target_addr = '0;
      xfer_active = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      base = steps_done;
      test_write_transfer();
      test_write_read_transfer();
      test_special_cases();
      test_pointer_saturation();
      test_random_traffic(550 - (steps_done - base));

      req_tvalid = 1'b0;
      while (bus_steps_due.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("covered %0d effective requests, %0d results checked; transfers ended: %0d write,",
               steps_done, checked, ends_by_outcome[OC_WRITE_DONE]);
      $display("%0d read, %0d on unexpected status; %0d begins rejected",
               ends_by_outcome[OC_READ_DONE], ends_by_outcome[OC_UNEXPECTED],
               ends_by_outcome[OC_REJECTED]);
      if (errors == 0 && bus_steps_due.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
